FILE: design/cflba_pkg.sv
// Shared types, codes and widths for the chunked free-list block allocator.
// Used by the allocator top level and its shared multiplier; depends on nothing.
package cflba_pkg;

	// Default sizing of the allocator.
	localparam int MAX_CHUNKS_DEF       = 16;
	localparam int BLOCKS_PER_CHUNK_DEF = 255;

	// Field widths of the stream items and configuration registers.
	localparam int OP_W       = 2;
	localparam int CHUNK_W    = 4;
	localparam int BLOCK_W    = 8;
	localparam int STATUS_W   = 2;
	localparam int OFFSET_W   = 24;
	localparam int SIZE_W     = 16;
	localparam int COUNT_W    = 8;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 40;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// Shared multiplier operand and product widths.
	localparam int MUL_A_W = 8;
	localparam int MUL_B_W = 16;
	localparam int PROD_W  = 24;

	// Operation codes carried in the input tuser.
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	// Status codes carried in the output tuser.
	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_MEMORY  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 2'd2;

	// Configuration register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd1;
	localparam logic [SIZE_W-1:0]    BLOCK_SIZE_RST  = 16'd16;
	localparam logic [COUNT_W-1:0]   BLOCK_COUNT_RST = 8'd255;

	// Per-chunk bookkeeping entry: free-list head and free-block count.
	typedef struct packed {
		logic [BLOCK_W-1:0] head;
		logic [COUNT_W-1:0] count;
	} chunk_entry_t;

endpackage

FILE: design/cflba_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Stand-alone; used for the link store and the chunk bookkeeping store.
module cflba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: design/cflba_mul.sv
// Shared multiplier of the allocator: 8 x 16 bit product, registered.
// Depends on cflba_pkg for operand and product widths.
module cflba_mul (
	input  logic                     clk,
	input  logic [cflba_pkg::MUL_A_W-1:0] a,
	input  logic [cflba_pkg::MUL_B_W-1:0] b,
	output logic [cflba_pkg::PROD_W-1:0]  prod
);

	import cflba_pkg::*;

	logic [PROD_W-1:0] prod_q;

	// One product per cycle; the sequencer picks the operands.
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign prod = prod_q;

endmodule

FILE: design/chunked_free_list_block_allocator.sv
// Allocate: decode; if the current chunk is full, a scan of the chunks in use through
// the bookkeeping RAM port and, if none has room, the opening of a new chunk; then
// S_ALC_ADDR and S_ALC_LINK. Free: decode and S_FREE_ADDR (decode only for a rejected
// handle); query and bad opcodes: decode only. Each reply waits in S_RESP for the output
// register, and only then is a new item taken. After reset a clearing pass presets the
// MAX_CHUNKS * BLOCKS_PER_CHUNK links (4080 by default); no item is accepted meanwhile.
module chunked_free_list_block_allocator #(
	parameter int MAX_CHUNKS       = cflba_pkg::MAX_CHUNKS_DEF,
	parameter int BLOCKS_PER_CHUNK = cflba_pkg::BLOCKS_PER_CHUNK_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input stream.
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// tdata: chunk_index [3:0], block_index [11:4], zero [15:12]
	input  logic [cflba_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// tuser: opcode [1:0]
	input  logic [cflba_pkg::OP_W-1:0]        s_axis_tuser,
	// Output stream.
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// tdata: result_chunk [3:0], result_block [11:4], byte_offset [35:12], found [36],
	// zero [39:37]
	output logic [cflba_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// tuser: status [1:0]
	output logic [cflba_pkg::STATUS_W-1:0]    m_axis_tuser,
	// Configuration write port.
	input  logic                              cfg_we,
	input  logic [cflba_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cflba_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import cflba_pkg::*;

	localparam int CA_W       = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int CU_W       = $clog2(MAX_CHUNKS + 1);
	localparam int HC_W       = CU_W + CHUNK_W;
	localparam int CX_W       = CA_W + CHUNK_W;
	localparam int LINK_DEPTH = MAX_CHUNKS * BLOCKS_PER_CHUNK;
	localparam int LA_W       = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;

	localparam logic [BLOCK_W-1:0] BPC_B   = BLOCK_W'(BLOCKS_PER_CHUNK);
	localparam logic [MUL_B_W-1:0] BPC_M   = MUL_B_W'(BLOCKS_PER_CHUNK);
	localparam logic [BLOCK_W-1:0] CLR_END = BLOCK_W'(BLOCKS_PER_CHUNK - 1);
	localparam logic [LA_W-1:0]    LK_END  = LA_W'(LINK_DEPTH - 1);
	localparam logic [CU_W-1:0]    CU_FULL = CU_W'(MAX_CHUNKS);

	typedef enum logic [8:0] {
		S_CLEAR     = 9'b000000001,
		S_IDLE      = 9'b000000010,
		S_DECODE    = 9'b000000100,
		S_SCAN      = 9'b000001000,
		S_OPEN      = 9'b000010000,
		S_ALC_ADDR  = 9'b000100000,
		S_ALC_LINK  = 9'b001000000,
		S_FREE_ADDR = 9'b010000000,
		S_RESP      = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	// Configuration registers.
	logic [SIZE_W-1:0]  block_size_q;
	logic [COUNT_W-1:0] block_count_q;
	logic [COUNT_W-1:0] eff_count;

	// Captured input item.
	logic [OP_W-1:0]    op_q, op_d;
	logic [CHUNK_W-1:0] chk_q, chk_d;
	logic [BLOCK_W-1:0] blk_q, blk_d;

	// Allocator state and sequencer working registers.
	logic [CA_W-1:0]    alloc_chunk_q, alloc_chunk_d;
	logic [CU_W-1:0]    chunks_in_use_q, chunks_in_use_d;
	logic [CA_W-1:0]    scan_idx_q, scan_idx_d;
	logic [BLOCK_W-1:0] head_q, head_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [LA_W-1:0]    clr_addr_q, clr_addr_d;
	logic [BLOCK_W-1:0] clr_blk_q, clr_blk_d;

	// Result staging and output register.
	logic                res_load;
	logic [STATUS_W-1:0] res_status_q, res_status_n;
	logic [CHUNK_W-1:0]  res_chunk_q, res_chunk_n;
	logic [BLOCK_W-1:0]  res_block_q, res_block_n;
	logic [OFFSET_W-1:0] res_offset_q, res_offset_n;
	logic                res_found_q, res_found_n;
	logic                out_valid_q, out_valid_d;
	logic                out_load;
	logic [OUT_DATA_W-1:0] out_tdata_q;
	logic [STATUS_W-1:0]   out_tuser_q;

	// Memory ports.
	logic               cs_we;
	logic [CA_W-1:0]    cs_waddr, cs_raddr;
	chunk_entry_t       cs_wdata, cs_rdata;
	logic               lk_we;
	logic [LA_W-1:0]    lk_waddr, lk_raddr, lk_addr;
	logic [BLOCK_W-1:0] lk_wdata, lk_rdata;

	// Shared multiplier.
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  prod;

	// Helpers.
	logic               accept, out_free;
	logic [CX_W-1:0]    in_chk_wide, chk_wide, res_chk_wide;
	logic [CA_W-1:0]    in_chk_addr, chk_addr, open_chunk;
	logic [CU_W-1:0]    scan_nxt;
	logic               handle_ok, alloc_valid;
	logic [BLOCK_W-1:0] lk_off;
	logic [PROD_W-1:0]  lk_sum;
	logic               alc_go;
	logic [CA_W-1:0]    alc_chunk;
	logic [BLOCK_W-1:0] alc_head;
	logic [COUNT_W-1:0] alc_count;

	// Bookkeeping store: head and free count per chunk.
	cflba_ram #(
		.WIDTH ($bits(chunk_entry_t)),
		.DEPTH (MAX_CHUNKS)
	) u_chunk_ram (
		.clk   (clk),
		.we    (cs_we),
		.waddr (cs_waddr),
		.wdata (cs_wdata),
		.raddr (cs_raddr),
		.rdata (cs_rdata)
	);

	// Link store: next free block for every block of every chunk.
	cflba_ram #(
		.WIDTH (BLOCK_W),
		.DEPTH (LINK_DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (lk_we),
		.waddr (lk_waddr),
		.wdata (lk_wdata),
		.raddr (lk_raddr),
		.rdata (lk_rdata)
	);

	cflba_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// Handshakes.
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_tdata_q;
	assign m_axis_tuser  = out_tuser_q;

	// Block count in effect, capped at the chunk capacity.
	assign eff_count = (block_count_q > BPC_B) ? BPC_B : block_count_q;

	// Chunk numbers of the handle mapped onto the bookkeeping address width.
	assign in_chk_wide = CX_W'(s_axis_tdata[CHUNK_W-1:0]);
	assign in_chk_addr = in_chk_wide[CA_W-1:0];
	assign chk_wide    = CX_W'(chk_q);
	assign chk_addr    = chk_wide[CA_W-1:0];
	assign open_chunk  = chunks_in_use_q[CA_W-1:0];
	assign scan_nxt    = CU_W'(scan_idx_q) + CU_W'(1);
	assign res_chk_wide = CX_W'(alloc_chunk_q);

	assign handle_ok   = (HC_W'(chk_q) < HC_W'(chunks_in_use_q)) && (blk_q < eff_count);
	assign alloc_valid = (chunks_in_use_q != '0) && (CU_W'(alloc_chunk_q) < chunks_in_use_q);

	// Link address: chunk base from the multiplier plus the block within the chunk.
	assign lk_off  = (state_q == S_FREE_ADDR) ? blk_q : head_q;
	assign lk_sum  = prod + PROD_W'(lk_off);
	assign lk_addr = lk_sum[LA_W-1:0];

	// Sequencer and datapath control.
	always_comb begin
		state_d         = state_q;
		op_d            = op_q;
		chk_d           = chk_q;
		blk_d           = blk_q;
		alloc_chunk_d   = alloc_chunk_q;
		chunks_in_use_d = chunks_in_use_q;
		scan_idx_d      = scan_idx_q;
		head_d          = head_q;
		count_d         = count_q;
		clr_addr_d      = clr_addr_q;
		clr_blk_d       = clr_blk_q;
		out_valid_d     = out_valid_q && !m_axis_tready;
		out_load        = 1'b0;
		res_load        = 1'b0;
		res_status_n    = ST_BAD_HANDLE;
		res_chunk_n     = '0;
		res_block_n     = '0;
		res_offset_n    = '0;
		res_found_n     = 1'b0;
		cs_we           = 1'b0;
		cs_waddr        = alloc_chunk_q;
		cs_wdata        = '0;
		cs_raddr        = alloc_chunk_q;
		lk_we           = 1'b0;
		lk_waddr        = lk_addr;
		lk_wdata        = head_q;
		lk_raddr        = lk_addr;
		mul_a           = '0;
		mul_b           = BPC_M;
		alc_go          = 1'b0;
		alc_chunk       = alloc_chunk_q;
		alc_head        = cs_rdata.head;
		alc_count       = cs_rdata.count;

		unique case (state_q)
			S_CLEAR: begin
				// Preset every link to its own block index plus one.
				lk_we     = 1'b1;
				lk_waddr  = clr_addr_q;
				lk_wdata  = clr_blk_q + 8'd1;
				clr_addr_d = clr_addr_q + LA_W'(1);
				clr_blk_d  = (clr_blk_q == CLR_END) ? '0 : clr_blk_q + 8'd1;
				if (clr_addr_q == LK_END) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				// Fetch the chunk entry that the operation will look at first.
				cs_raddr = (s_axis_tuser == OP_ALLOC) ? alloc_chunk_q : in_chk_addr;
				if (accept) begin
					op_d    = s_axis_tuser;
					chk_d   = s_axis_tdata[CHUNK_W-1:0];
					blk_d   = s_axis_tdata[CHUNK_W+BLOCK_W-1:CHUNK_W];
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (op_q)
					OP_ALLOC: begin
						if (alloc_valid && cs_rdata.count != '0) begin
							alc_go = 1'b1;
						end else if (chunks_in_use_q == '0) begin
							state_d = S_OPEN;
						end else begin
							cs_raddr   = '0;
							scan_idx_d = '0;
							state_d    = S_SCAN;
						end
					end
					OP_FREE: begin
						if (handle_ok) begin
							head_d  = cs_rdata.head;
							count_d = cs_rdata.count;
							mul_a   = MUL_A_W'(chk_addr);
							state_d = S_FREE_ADDR;
						end else begin
							res_load = 1'b1;
							state_d  = S_RESP;
						end
					end
					OP_QUERY: begin
						res_load = 1'b1;
						state_d  = S_RESP;
						if (handle_ok) begin
							res_status_n = ST_OK;
							res_found_n  = 1'b1;
						end
					end
					default: begin
						res_load = 1'b1;
						state_d  = S_RESP;
					end
				endcase
			end
			S_SCAN: begin
				// One chunk per cycle, lowest number first.
				if (cs_rdata.count != '0) begin
					alc_go    = 1'b1;
					alc_chunk = scan_idx_q;
				end else if (scan_nxt == chunks_in_use_q) begin
					state_d = S_OPEN;
				end else begin
					scan_idx_d = scan_nxt[CA_W-1:0];
					cs_raddr   = scan_nxt[CA_W-1:0];
				end
			end
			S_OPEN: begin
				if (chunks_in_use_q == CU_FULL || eff_count == '0) begin
					res_status_n = ST_NO_MEMORY;
					res_load     = 1'b1;
					state_d      = S_RESP;
				end else begin
					cs_we           = 1'b1;
					cs_waddr        = open_chunk;
					cs_wdata.head   = '0;
					cs_wdata.count  = eff_count;
					chunks_in_use_d = chunks_in_use_q + CU_W'(1);
					alc_go          = 1'b1;
					alc_chunk       = open_chunk;
					alc_head        = '0;
					alc_count       = eff_count;
				end
			end
			S_ALC_ADDR: begin
				// Link read at the chunk base plus head; start the byte offset product.
				mul_a   = MUL_A_W'(head_q);
				mul_b   = block_size_q;
				state_d = S_ALC_LINK;
			end
			S_ALC_LINK: begin
				cs_we          = 1'b1;
				cs_waddr       = alloc_chunk_q;
				cs_wdata.head  = lk_rdata;
				cs_wdata.count = count_q - 8'd1;
				res_status_n   = ST_OK;
				res_chunk_n    = res_chk_wide[CHUNK_W-1:0];
				res_block_n    = head_q;
				res_offset_n   = prod[OFFSET_W-1:0];
				res_load       = 1'b1;
				state_d        = S_RESP;
			end
			S_FREE_ADDR: begin
				// Push the block: its link takes the old head, the head takes the block.
				lk_we          = 1'b1;
				cs_we          = 1'b1;
				cs_waddr       = chk_addr;
				cs_wdata.head  = blk_q;
				cs_wdata.count = (count_q == 8'hFF) ? count_q : count_q + 8'd1;
				res_status_n   = ST_OK;
				res_load       = 1'b1;
				state_d        = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					out_load    = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Start of an allocation from a chunk with free blocks.
		if (alc_go) begin
			alloc_chunk_d = alc_chunk;
			if (alc_head >= BPC_B) begin
				res_status_n = ST_NO_MEMORY;
				res_load     = 1'b1;
				state_d      = S_RESP;
			end else begin
				head_d  = alc_head;
				count_d = alc_count;
				mul_a   = MUL_A_W'(alc_chunk);
				state_d = S_ALC_ADDR;
			end
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_CLEAR;
			alloc_chunk_q   <= '0;
			chunks_in_use_q <= '0;
			clr_addr_q      <= '0;
			clr_blk_q       <= '0;
			out_valid_q     <= 1'b0;
			block_size_q    <= BLOCK_SIZE_RST;
			block_count_q   <= BLOCK_COUNT_RST;
		end else begin
			state_q         <= state_d;
			alloc_chunk_q   <= alloc_chunk_d;
			chunks_in_use_q <= chunks_in_use_d;
			clr_addr_q      <= clr_addr_d;
			clr_blk_q       <= clr_blk_d;
			out_valid_q     <= out_valid_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_BLOCK_SIZE:  block_size_q  <= cfg_data;
					CFG_BLOCK_COUNT: block_count_q <= cfg_data[COUNT_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		op_q       <= op_d;
		chk_q      <= chk_d;
		blk_q      <= blk_d;
		scan_idx_q <= scan_idx_d;
		head_q     <= head_d;
		count_q    <= count_d;
		if (res_load) begin
			res_status_q <= res_status_n;
			res_chunk_q  <= res_chunk_n;
			res_block_q  <= res_block_n;
			res_offset_q <= res_offset_n;
			res_found_q  <= res_found_n;
		end
		if (out_load) begin
			out_tdata_q <= {3'b000, res_found_q, res_offset_q, res_block_q, res_chunk_q};
			out_tuser_q <= res_status_q;
		end
	end

	// Chunk count never passes the number of chunks.
	a_cu_bound: assert property (@(posedge clk) disable iff (!arst_n)
		chunks_in_use_q <= CU_FULL)
		else $error("chunks in use exceeds the chunk count");

	// Chunks are opened one at a time and never closed.
	a_cu_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (chunks_in_use_q == $past(chunks_in_use_q) ||
			chunks_in_use_q == $past(chunks_in_use_q) + CU_W'(1)))
		else $error("chunks in use changed by more than one");

	// An allocation completes only from a chunk in use with a head inside the chunk.
	a_alloc_src: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALC_LINK) |->
			(head_q < BPC_B && CU_W'(alloc_chunk_q) < chunks_in_use_q))
		else $error("allocation from a chunk not in use or a bad head");

	// Bookkeeping writes outside chunk opening only touch chunks in use.
	a_cs_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cs_we && state_q != S_OPEN) |-> (CU_W'(cs_waddr) < chunks_in_use_q))
		else $error("bookkeeping write to a chunk not in use");

	// A result appears only out of the response state.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_RESP))
		else $error("result raised outside the response state");

endmodule

FILE: tb/chunked_free_list_block_allocator_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the chunked free-list block allocator.
// It tracks chunk counts, list heads and block links alongside the block and checks every reply.
// Depends on cflba_pkg and the chunked_free_list_block_allocator top level.
module chunked_free_list_block_allocator_tb;
	import cflba_pkg::*;

	localparam int NCH  = MAX_CHUNKS_DEF;
	localparam int NBLK = BLOCKS_PER_CHUNK_DEF;
	// Opcode outside the defined set; the block must reject it.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CHUNK_W-1:0]  chunk;
		logic [BLOCK_W-1:0]  blk;
		logic [OFFSET_W-1:0] offset;
		logic                found;
	} reply_t;

	typedef struct packed {
		logic [CHUNK_W-1:0] chunk;
		logic [BLOCK_W-1:0] blk;
	} handle_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [OP_W-1:0]       s_axis_tuser = OP_ALLOC;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [STATUS_W-1:0]   m_axis_tuser;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_BLOCK_SIZE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow copy of the allocator state.
	logic [BLOCK_W-1:0] link_mem [NCH][NBLK];
	logic [COUNT_W-1:0] free_cnt [NCH];
	logic [BLOCK_W-1:0] head [NCH];
	int                 open_chunks = 0;
	int                 cur_chunk = 0;
	int                 last_touched = 0;
	logic [SIZE_W-1:0]  cfg_size = BLOCK_SIZE_RST;
	logic [COUNT_W-1:0] cfg_count = BLOCK_COUNT_RST;

	reply_t  replies_due [$];
	handle_t held_blocks [$];
	int      mismatches = 0;
	int      hold_off_cycles = 0;
	bit      src_idle = 1'b1;
	bit      sink_idle = 1'b1;

	chunked_free_list_block_allocator uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Blocks per newly opened chunk, clipped to the chunk capacity.
	function automatic int usable_blocks();
		return (cfg_count > NBLK) ? NBLK : int'(cfg_count);
	endfunction

	function automatic bit handle_valid(int c, int b);
		return c < open_chunks && c < NCH && b < usable_blocks();
	endfunction

	// Apply one transaction to the shadow state and return the reply it must produce.
	function automatic reply_t predict_reply(logic [OP_W-1:0] op, logic [CHUNK_W-1:0] c,
			logic [BLOCK_W-1:0] b);
		reply_t      r;
		bit          have;
		int          i;
		int          pick;
		logic [31:0] prod;
		r = '0;
		r.status = ST_BAD_HANDLE;
		case (op)
			OP_ALLOC: begin
				have = 1'b0;
				if (open_chunks > 0 && cur_chunk < open_chunks && free_cnt[cur_chunk] != 0) begin
					have = 1'b1;
				end else begin
					// The current chunk is full: take the lowest chunk in use with room.
					for (i = 0; i < open_chunks; i++) begin
						if (!have && free_cnt[i] != 0) begin
							cur_chunk = i;
							have = 1'b1;
						end
					end
					if (!have) begin
						if (open_chunks >= NCH || usable_blocks() == 0) begin
							r.status = ST_NO_MEMORY;
							return r;
						end
						free_cnt[open_chunks] = COUNT_W'(usable_blocks());
						head[open_chunks] = '0;
						cur_chunk = open_chunks;
						last_touched = open_chunks;
						open_chunks++;
					end
				end
				pick = head[cur_chunk];
				// A list head past the chunk means a corrupted list.
				if (pick >= NBLK) begin
					r.status = ST_NO_MEMORY;
					return r;
				end
				head[cur_chunk] = link_mem[cur_chunk][pick];
				free_cnt[cur_chunk] = free_cnt[cur_chunk] - 1'b1;
				prod = pick * cfg_size;
				r.status = ST_OK;
				r.chunk = CHUNK_W'(cur_chunk);
				r.blk = BLOCK_W'(pick);
				r.offset = prod[OFFSET_W-1:0];
			end
			OP_FREE: begin
				if (handle_valid(c, b)) begin
					link_mem[c][b] = head[c];
					head[c] = b;
					if (free_cnt[c] != 8'hff)
						free_cnt[c] = free_cnt[c] + 1'b1;
					last_touched = c;
					r.status = ST_OK;
				end
			end
			OP_QUERY: begin
				if (handle_valid(c, b)) begin
					last_touched = c;
					r.status = ST_OK;
					r.found = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Offer one transaction, after a random gap when src_idle is set, and record its expected reply once taken.
	task automatic send_item(logic [OP_W-1:0] op, logic [CHUNK_W-1:0] c, logic [BLOCK_W-1:0] b);
		int     gap;
		int     i;
		reply_t r;
		gap = src_idle ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {4'b0, b, c};
		do @(posedge clk); while (!s_axis_tready);
		r = predict_reply(op, c, b);
		replies_due.insert(replies_due.size(), r);
		// Keep track of the blocks handed out so that later frees are well formed.
		if (op == OP_ALLOC && r.status == ST_OK) begin
			held_blocks.insert(held_blocks.size(), {r.chunk, r.blk});
		end else if (op == OP_FREE && r.status == ST_OK) begin
			for (i = 0; i < held_blocks.size(); i++) begin
				if (held_blocks[i] == {c, b}) begin
					held_blocks.delete(i);
					break;
				end
			end
		end
	endtask

	// Stop offering and wait until every expected reply has been taken.
	task automatic wait_quiet();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (replies_due.size() != 0);
	endtask

	// Write both registers while the block is idle.
	task automatic set_config(logic [SIZE_W-1:0] size, logic [COUNT_W-1:0] count);
		wait_quiet();
		cfg_we <= 1'b1;
		cfg_index <= CFG_BLOCK_SIZE;
		cfg_data <= size;
		@(posedge clk);
		cfg_index <= CFG_BLOCK_COUNT;
		cfg_data <= {8'd0, count};
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_size = size;
		cfg_count = count;
	endtask

	// With a zero block count nothing can be opened and no handle is valid.
	task automatic test_zero_count();
		set_config(16'hffff, 8'd0);
		send_item(OP_ALLOC, 4'd0, 8'd0);
		send_item(OP_FREE, 4'd0, 8'd0);
		send_item(OP_QUERY, 4'd0, 8'd0);
		send_item(OP_UNUSED, 4'd0, 8'd0);
	endtask

	// Fill a two-block chunk, open the next one, then reuse a freed block by scanning.
	task automatic test_first_chunks();
		set_config(16'hffff, 8'd2);
		send_item(OP_ALLOC, 4'd0, 8'd0);
		send_item(OP_ALLOC, 4'd0, 8'd0);
		send_item(OP_ALLOC, 4'd0, 8'd0);
		send_item(OP_QUERY, 4'd1, 8'd1);
		send_item(OP_QUERY, 4'd2, 8'd0);
		send_item(OP_QUERY, 4'd0, 8'd2);
		send_item(OP_FREE, 4'd0, 8'd1);
		send_item(OP_ALLOC, 4'd0, 8'd0);
		send_item(OP_ALLOC, 4'd0, 8'd0);
	endtask

	// Largest block index, out-of-range handles, a double free and the largest offset.
	task automatic test_edge_handles();
		set_config(16'hffff, 8'd255);
		send_item(OP_QUERY, 4'd0, 8'd254);
		send_item(OP_FREE, 4'd0, 8'd254);
		send_item(OP_FREE, 4'd0, 8'd255);
		send_item(OP_QUERY, 4'd15, 8'd254);
		send_item(OP_ALLOC, 4'd0, 8'd0);
		send_item(OP_FREE, 4'd1, 8'd0);
		send_item(OP_FREE, 4'd1, 8'd0);
		send_item(OP_ALLOC, 4'd0, 8'd0);
		send_item(OP_ALLOC, 4'd0, 8'd0);
		send_item(OP_UNUSED, 4'd15, 8'd255);
	endtask

	// Mostly well-formed allocate, free and query traffic with some random noise.
	task automatic test_random_traffic(logic [SIZE_W-1:0] size, logic [COUNT_W-1:0] count,
			int n, bit src_mode, bit sink_mode);
		int                 roll;
		int                 k;
		logic [OP_W-1:0]    op;
		logic [CHUNK_W-1:0] c;
		logic [BLOCK_W-1:0] b;
		set_config(size, count);
		src_idle = src_mode;
		sink_idle = sink_mode;
		repeat (n) begin
			roll = $urandom_range(0, 99);
			op = OP_ALLOC;
			c = '0;
			b = '0;
			if (roll >= 48 && roll < 83 && held_blocks.size() > 0) begin
				k = $urandom_range(0, held_blocks.size() - 1);
				op = OP_FREE;
				c = held_blocks[k].chunk;
				b = held_blocks[k].blk;
			end else if (roll >= 83 && roll < 93) begin
				op = OP_QUERY;
				if (held_blocks.size() > 0 && $urandom_range(0, 1) == 1) begin
					k = $urandom_range(0, held_blocks.size() - 1);
					c = held_blocks[k].chunk;
					b = held_blocks[k].blk;
				end else begin
					c = CHUNK_W'($urandom_range(0, 15));
					b = BLOCK_W'($urandom_range(0, 255));
				end
			end else if (roll >= 93) begin
				op = OP_W'($urandom_range(0, 3));
				c = CHUNK_W'($urandom_range(0, 15));
				b = BLOCK_W'($urandom_range(0, 255));
			end
			send_item(op, c, b);
		end
	endtask

	// The receiver holds off for a long stretch while items keep coming back to back.
	task automatic test_backpressure();
		int i;
		src_idle = 1'b0;
		hold_off_cycles = 400;
		for (i = 0; i < 40; i++) begin
			if (i % 2 == 0)
				send_item(OP_ALLOC, 4'd0, 8'd0);
			else
				send_item(OP_QUERY, CHUNK_W'(i % 16), BLOCK_W'(i));
		end
	endtask

	// Receiver: random stalls per transaction when sink_idle is set, plus the long hold-off when asked.
	initial begin
		int w;
		forever begin
			if (hold_off_cycles > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
			end
			w = sink_idle ? $urandom_range(0, 13) : 0;
			if (w > 0) begin
				m_axis_tready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid && hold_off_cycles == 0);
		end
	end

	task automatic report_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Compare each reply transaction with the oldest expectation.
	always @(posedge clk) begin
		reply_t got;
		reply_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status = m_axis_tuser;
			got.chunk = m_axis_tdata[3:0];
			got.blk = m_axis_tdata[11:4];
			got.offset = m_axis_tdata[35:12];
			got.found = m_axis_tdata[36];
			if (replies_due.size() == 0) begin
				mismatches++;
				$display("%0t ns: reply mismatch, expected none, actual status %0d", $time,
					got.status);
			end else begin
				want = replies_due.pop_front();
				report_field("status", want.status, got.status);
				report_field("result_chunk", want.chunk, got.chunk);
				report_field("result_block", want.blk, got.blk);
				report_field("byte_offset", want.offset, got.offset);
				report_field("found", want.found, got.found);
			end
		end
	end

	initial begin
		int c;
		int b;
		// Link entries start out pointing at the next block; every chunk at full count.
		for (c = 0; c < NCH; c++) begin
			free_cnt[c] = BLOCK_COUNT_RST;
			head[c] = '0;
			for (b = 0; b < NBLK; b++)
				link_mem[c][b] = BLOCK_W'(b + 1);
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_zero_count();
		test_first_chunks();
		test_edge_handles();
		test_random_traffic(16'd1, 8'd3, 380, 1'b1, 1'b1);
		test_random_traffic(16'd16, 8'd1, 380, 1'b0, 1'b0);
		test_backpressure();
		test_random_traffic(16'd1000, 8'd2, 300, 1'b1, 1'b0);
		test_random_traffic(16'hffff, 8'd255, 380, 1'b0, 1'b1);
		test_random_traffic(16'd7, 8'd5, 300, 1'b1, 1'b1);
		test_random_traffic(16'd300, 8'd0, 160, 1'b1, 1'b1);
		wait_quiet();
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#3000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
design/cflba_pkg.sv
design/cflba_ram.sv
design/cflba_mul.sv
design/chunked_free_list_block_allocator.sv
tb/chunked_free_list_block_allocator_tb.sv
